// ===== design/qapm_pkg.sv =====
// Shared types, constants and sequencer step codes for the quad attitude PID mixer.
// No dependencies; every other design file refers to it by scoped names.
`default_nettype none

package qapm_pkg;

    localparam int PWM_FREQ_HZ_DEF = 400;

    // Fixed point
    localparam int MIN_PULSE_US = 1000;
    localparam int FRAC_SHIFT   = 24;
    localparam int MIX_W        = 46;
    localparam int W_W          = 36;
    localparam int X_W          = 28;
    localparam int Q_W          = 15;
    localparam int CNT_W        = 12;
    localparam int CNT_MAX      = 4095;

    // Shared multiplier operand widths
    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 30;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // count = floor((q24 * F + 2^17 * 15625) / (2^18 * 15625))
    localparam int          COUNT_SHIFT = 18;
    localparam int          DIV_ODD     = 15625;
    localparam logic [63:0] HALF_DIV    = 64'd2048000000;
    localparam int          RECIP_SHIFT = 42;
    localparam logic [28:0] RECIP_M     = 29'd281474976;

    // Item field widths and packing
    localparam int S_DATA_W = 192;
    localparam int M_DATA_W = 48;

    // Sequencer steps; a product issued in one step is consumed in the next
    localparam int STEP_W = 6;
    localparam logic [STEP_W-1:0] S_MUL_IP  = 6'd0;   // issue igain * pitch
    localparam logic [STEP_W-1:0] S_MUL_IR  = 6'd1;   // issue igain * roll, update pitch int
    localparam logic [STEP_W-1:0] S_MUL_PP  = 6'd2;   // issue pitch P, update roll int
    localparam logic [STEP_W-1:0] S_MUL_PD  = 6'd3;   // issue pitch D
    localparam logic [STEP_W-1:0] S_MUL_RP  = 6'd4;   // issue roll P
    localparam logic [STEP_W-1:0] S_MUL_RD  = 6'd5;   // issue roll D
    localparam logic [STEP_W-1:0] S_MUL_YAW = 6'd6;   // issue yaw gyro term
    localparam logic [STEP_W-1:0] S_YAW_PT  = 6'd7;
    localparam logic [STEP_W-1:0] S_RT_TY   = 6'd8;
    localparam logic [STEP_W-1:0] S_XY      = 6'd9;
    localparam logic [STEP_W-1:0] S_EF      = 6'd10;
    localparam logic [STEP_W-1:0] S_MOTOR   = 6'd11;  // four motors, eight phases each
    localparam logic [STEP_W-1:0] S_LAST    = 6'd42;

    // Phases of one motor's count conversion
    localparam logic [2:0] PH_CLAMP     = 3'd0;
    localparam logic [2:0] PH_MUL_LO    = 3'd1;
    localparam logic [2:0] PH_MUL_HI    = 3'd2;
    localparam logic [2:0] PH_SUM       = 3'd3;
    localparam logic [2:0] PH_MUL_RECIP = 3'd4;
    localparam logic [2:0] PH_QUOT      = 3'd5;
    localparam logic [2:0] PH_MUL_BACK  = 3'd6;
    localparam logic [2:0] PH_FIX       = 3'd7;

    typedef enum logic [2:0] {
        REG_PITCH_P_GAIN    = 3'd0,
        REG_ROLL_P_GAIN     = 3'd1,
        REG_RATE_D_GAIN     = 3'd2,
        REG_INTEGRAL_GAIN   = 3'd3,
        REG_INTEGRAL_LIMIT  = 3'd4,
        REG_YAW_RATE_GAIN   = 3'd5,
        REG_MAX_POWER_US    = 3'd6,
        REG_OUTPUTS_ENABLED = 3'd7
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [15:0] pitch_p_gain;
        logic [15:0] roll_p_gain;
        logic [15:0] rate_d_gain;
        logic [15:0] integral_gain;
        logic [14:0] integral_limit;
        logic [15:0] yaw_rate_gain;
        logic [11:0] max_power_us;
        logic        outputs_enabled;
    } cfg_t;

    typedef struct packed {
        logic              load;
        logic              run;
        logic              push;
        logic [STEP_W-1:0] step;
    } ctrl_t;

endpackage

`default_nettype wire

// ===== design/qapm_cfg.sv =====
// Configuration register file of the quad attitude PID mixer.
// Depends on qapm_pkg for the register index codes and the cfg_t bundle.
`default_nettype none

module qapm_cfg (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          cfg_wr_en,
    input  wire logic [2:0]    cfg_index,
    input  wire logic [15:0]   cfg_wr_data,
    output qapm_pkg::cfg_t     cfg
);

    qapm_pkg::cfg_t cfg_reg;
    qapm_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (qapm_pkg::cfg_idx_t'(cfg_index))
                qapm_pkg::REG_PITCH_P_GAIN:    cfg_next.pitch_p_gain    = cfg_wr_data;
                qapm_pkg::REG_ROLL_P_GAIN:     cfg_next.roll_p_gain     = cfg_wr_data;
                qapm_pkg::REG_RATE_D_GAIN:     cfg_next.rate_d_gain     = cfg_wr_data;
                qapm_pkg::REG_INTEGRAL_GAIN:   cfg_next.integral_gain   = cfg_wr_data;
                qapm_pkg::REG_INTEGRAL_LIMIT:  cfg_next.integral_limit  = cfg_wr_data[14:0];
                qapm_pkg::REG_YAW_RATE_GAIN:   cfg_next.yaw_rate_gain   = cfg_wr_data;
                qapm_pkg::REG_MAX_POWER_US:    cfg_next.max_power_us    = cfg_wr_data[11:0];
                qapm_pkg::REG_OUTPUTS_ENABLED: cfg_next.outputs_enabled = cfg_wr_data[0];
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pitch_p_gain    <= 16'd2560;
            cfg_reg.roll_p_gain     <= 16'd2304;
            cfg_reg.rate_d_gain     <= 16'd56320;
            cfg_reg.integral_gain   <= 16'd5898;
            cfg_reg.integral_limit  <= 15'd25600;
            cfg_reg.yaw_rate_gain   <= 16'd39322;
            cfg_reg.max_power_us    <= 12'd1900;
            cfg_reg.outputs_enabled <= 1'b1;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== design/qapm_mul.sv =====
// Shared signed multiplier with a registered product.
// Depends on qapm_pkg for the operand widths.
`default_nettype none

module qapm_mul (
    input  wire logic                                   aclk,
    input  wire logic signed [qapm_pkg::MUL_A_W-1:0]    mul_a,
    input  wire logic signed [qapm_pkg::MUL_B_W-1:0]    mul_b,
    output logic signed [qapm_pkg::PROD_W-1:0]          prod
);

    logic signed [qapm_pkg::PROD_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= qapm_pkg::PROD_W'(mul_a) * qapm_pkg::PROD_W'(mul_b);
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

// ===== design/qapm_ctrl.sv =====
// Sequencer of the quad attitude PID mixer: input handshake, step counter, result hand-off.
// Depends on qapm_pkg for the state type, step codes and the ctrl_t bundle.
`default_nettype none

module qapm_ctrl (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic       out_free,
    input  wire logic       outputs_enabled,
    output qapm_pkg::ctrl_t ctrl
);

    qapm_pkg::state_t                 state_reg, state_next;
    logic [qapm_pkg::STEP_W-1:0]      step_reg, step_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= qapm_pkg::ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        s_tready   = 1'b0;
        ctrl.load  = 1'b0;
        ctrl.run   = 1'b0;
        ctrl.push  = 1'b0;
        ctrl.step  = step_reg;
        unique case (state_reg)
            qapm_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    ctrl.load  = 1'b1;
                    step_next  = '0;
                    state_next = qapm_pkg::ST_RUN;
                end
            end
            qapm_pkg::ST_RUN: begin
                ctrl.run  = 1'b1;
                step_next = step_reg + 1'b1;
                if (step_reg == qapm_pkg::S_LAST) begin
                    state_next = qapm_pkg::ST_DONE;
                end
            end
            qapm_pkg::ST_DONE: begin
                // hold until the output register can take the beat
                if (out_free) begin
                    ctrl.push  = outputs_enabled;
                    state_next = qapm_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = qapm_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== design/qapm_dpath.sv =====
// Datapath of the quad attitude PID mixer: item registers, integrators, mix and count conversion.
// Depends on qapm_pkg and instantiates the shared multiplier qapm_mul.
`default_nettype none

module qapm_dpath #(
    parameter int PWM_FREQ_HZ = qapm_pkg::PWM_FREQ_HZ_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire qapm_pkg::ctrl_t                   ctrl,
    input  wire qapm_pkg::cfg_t                    cfg,
    input  wire logic [qapm_pkg::S_DATA_W-1:0]     s_tdata,
    input  wire logic                              s_tuser,
    output logic [qapm_pkg::M_DATA_W-1:0]          counts
);

    localparam int MIX_W  = qapm_pkg::MIX_W;
    localparam int PROD_W = qapm_pkg::PROD_W;
    localparam int X_W    = qapm_pkg::X_W;
    localparam int Q_W    = qapm_pkg::Q_W;
    localparam int CNT_W  = qapm_pkg::CNT_W;

    localparam logic signed [MIX_W-1:0] LO_Q24 =
        MIX_W'(qapm_pkg::MIN_PULSE_US) <<< qapm_pkg::FRAC_SHIFT;
    localparam logic [63:0] CNT_BIAS =
        64'(qapm_pkg::MIN_PULSE_US) * 64'(PWM_FREQ_HZ) * (64'd1 << qapm_pkg::FRAC_SHIFT)
        + qapm_pkg::HALF_DIV;

    // captured item
    logic [qapm_pkg::S_DATA_W-1:0] item_reg;
    logic                          fly_reg;

    logic signed [15:0] pa, ra, pc, rc;
    logic signed [17:0] yg, sr, sp, hr, hp, yc;
    logic signed [19:0] th;

    assign pa = $signed(item_reg[15:0]);
    assign ra = $signed(item_reg[31:16]);
    assign pc = $signed(item_reg[47:32]);
    assign rc = $signed(item_reg[63:48]);
    assign yg = $signed(item_reg[81:64]);
    assign th = $signed(item_reg[101:82]);
    assign sr = $signed(item_reg[119:102]);
    assign sp = $signed(item_reg[137:120]);
    assign hr = $signed(item_reg[155:138]);
    assign hp = $signed(item_reg[173:156]);
    assign yc = $signed(item_reg[191:174]);

    // shared multiplier
    logic signed [qapm_pkg::MUL_A_W-1:0] mul_a;
    logic signed [qapm_pkg::MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]            prod;

    qapm_mul u_mul (
        .aclk  (aclk),
        .mul_a (mul_a),
        .mul_b (mul_b),
        .prod  (prod)
    );

    // integrators and mix terms
    logic signed [15:0]       pi_reg, ri_reg;
    logic signed [MIX_W-1:0]  acc_p_reg, acc_r_reg, yt_reg, pt_reg, rt_reg;
    logic signed [MIX_W-1:0]  u_reg, v_reg, tys_reg, tyd_reg, xs_reg, ys_reg, e_reg, f_reg;

    // count conversion
    logic [qapm_pkg::W_W-1:0] w_reg;
    logic [26:0]              low_reg;
    logic [X_W-1:0]           x_reg;
    logic [Q_W-1:0]           q_reg;
    logic [CNT_W-1:0]         cnt_reg [4];

    // step decode
    logic [qapm_pkg::STEP_W-1:0] rel;
    logic [1:0]                  motor;
    logic [2:0]                  phase;
    logic                        in_motor;

    assign rel      = ctrl.step - qapm_pkg::S_MOTOR;
    assign motor    = rel[4:3];
    assign phase    = rel[2:0];
    assign in_motor = (ctrl.step >= qapm_pkg::S_MOTOR);

    function automatic logic signed [15:0] int_step(
        input logic signed [15:0]       acc,
        input logic signed [PROD_W-1:0] p,
        input logic [14:0]              lim
    );
        logic signed [PROD_W-1:0] rnd;
        logic signed [18:0]       sum;
        logic signed [18:0]       lim_s;
        rnd   = (p + $signed(PROD_W'(32768))) >>> 16;
        sum   = 19'(acc) + 19'(rnd);
        lim_s = $signed({4'b0000, lim});
        if (sum > lim_s) begin
            sum = lim_s;
        end else if (sum < -lim_s) begin
            sum = -lim_s;
        end
        return 16'(sum);
    endfunction

    // operand select for the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (in_motor) begin
            unique case (phase)
                qapm_pkg::PH_MUL_LO: begin
                    mul_a = qapm_pkg::MUL_A_W'(w_reg[17:0]);
                    mul_b = qapm_pkg::MUL_B_W'(PWM_FREQ_HZ);
                end
                qapm_pkg::PH_MUL_HI: begin
                    mul_a = qapm_pkg::MUL_A_W'(w_reg[35:18]);
                    mul_b = qapm_pkg::MUL_B_W'(PWM_FREQ_HZ);
                end
                qapm_pkg::PH_MUL_RECIP: begin
                    mul_a = qapm_pkg::MUL_A_W'(x_reg);
                    mul_b = qapm_pkg::MUL_B_W'(qapm_pkg::RECIP_M);
                end
                qapm_pkg::PH_MUL_BACK: begin
                    mul_a = qapm_pkg::MUL_A_W'(q_reg);
                    mul_b = qapm_pkg::MUL_B_W'(qapm_pkg::DIV_ODD);
                end
                default: begin
                    mul_a = '0;
                    mul_b = '0;
                end
            endcase
        end else begin
            unique case (ctrl.step)
                qapm_pkg::S_MUL_IP: begin
                    mul_a = qapm_pkg::MUL_A_W'(pa);
                    mul_b = qapm_pkg::MUL_B_W'(cfg.integral_gain);
                end
                qapm_pkg::S_MUL_IR: begin
                    mul_a = qapm_pkg::MUL_A_W'(ra);
                    mul_b = qapm_pkg::MUL_B_W'(cfg.integral_gain);
                end
                qapm_pkg::S_MUL_PP: begin
                    mul_a = qapm_pkg::MUL_A_W'(pa);
                    mul_b = qapm_pkg::MUL_B_W'(cfg.pitch_p_gain);
                end
                qapm_pkg::S_MUL_PD: begin
                    mul_a = qapm_pkg::MUL_A_W'(pc);
                    mul_b = qapm_pkg::MUL_B_W'(cfg.rate_d_gain);
                end
                qapm_pkg::S_MUL_RP: begin
                    mul_a = qapm_pkg::MUL_A_W'(ra);
                    mul_b = qapm_pkg::MUL_B_W'(cfg.roll_p_gain);
                end
                qapm_pkg::S_MUL_RD: begin
                    mul_a = qapm_pkg::MUL_A_W'(rc);
                    mul_b = qapm_pkg::MUL_B_W'(cfg.rate_d_gain);
                end
                qapm_pkg::S_MUL_YAW: begin
                    mul_a = qapm_pkg::MUL_A_W'(yg);
                    mul_b = qapm_pkg::MUL_B_W'(cfg.yaw_rate_gain);
                end
                default: begin
                    mul_a = '0;
                    mul_b = '0;
                end
            endcase
        end
    end

    // motor width select, clamp and reduction steps
    logic [11:0]              pwr_top;
    logic signed [MIX_W-1:0]  hi_q24;
    logic signed [MIX_W-1:0]  m_sel;
    logic signed [MIX_W-1:0]  m_clamp;
    logic [qapm_pkg::W_W-1:0] w_next;
    logic [26:0]              low_next;
    logic [X_W-1:0]           x_next;
    logic [X_W-1:0]           rem;
    logic [Q_W:0]             q_fix;
    logic [CNT_W-1:0]         cnt_fix;

    always_comb begin
        pwr_top = (cfg.max_power_us < 12'(qapm_pkg::MIN_PULSE_US))
                ? 12'(qapm_pkg::MIN_PULSE_US) : cfg.max_power_us;
        hi_q24  = $signed(MIX_W'(pwr_top) << qapm_pkg::FRAC_SHIFT);
        unique case (motor)
            2'd0: m_sel = tys_reg + e_reg;
            2'd1: m_sel = tyd_reg + f_reg;
            2'd2: m_sel = tyd_reg - f_reg;
            2'd3: m_sel = tys_reg - e_reg;
        endcase
        if (m_sel > hi_q24) begin
            m_clamp = hi_q24;
        end else if (m_sel < LO_Q24) begin
            m_clamp = LO_Q24;
        end else begin
            m_clamp = m_sel;
        end
        // paused: every motor sits at the minimum pulse
        w_next   = fly_reg ? qapm_pkg::W_W'(m_clamp - LO_Q24) : '0;
        low_next = 27'((CNT_BIAS + 64'(prod[X_W-1:0])) >> qapm_pkg::COUNT_SHIFT);
        x_next   = prod[X_W-1:0] + X_W'(low_reg);
        rem      = x_reg - prod[X_W-1:0];
        q_fix    = (Q_W + 1)'(q_reg) + (Q_W + 1)'(rem >= X_W'(qapm_pkg::DIV_ODD));
        cnt_fix  = (q_fix > (Q_W + 1)'(qapm_pkg::CNT_MAX))
                 ? CNT_W'(qapm_pkg::CNT_MAX) : q_fix[CNT_W-1:0];
    end

    // item capture and payload registers
    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            item_reg <= s_tdata;
            fly_reg  <= s_tuser;
        end
        if (ctrl.run) begin
            if (in_motor) begin
                unique case (phase)
                    qapm_pkg::PH_CLAMP:     w_reg   <= w_next;
                    qapm_pkg::PH_MUL_LO:    ;
                    qapm_pkg::PH_MUL_HI:    low_reg <= low_next;
                    qapm_pkg::PH_SUM:       x_reg   <= x_next;
                    qapm_pkg::PH_MUL_RECIP: ;
                    qapm_pkg::PH_QUOT:      q_reg   <= prod[qapm_pkg::RECIP_SHIFT +: Q_W];
                    qapm_pkg::PH_MUL_BACK:  ;
                    qapm_pkg::PH_FIX:       cnt_reg[motor] <= cnt_fix;
                endcase
            end else begin
                unique case (ctrl.step)
                    qapm_pkg::S_MUL_PD:  acc_p_reg <= MIX_W'(prod);
                    qapm_pkg::S_MUL_RP:  acc_p_reg <= acc_p_reg + MIX_W'(prod);
                    qapm_pkg::S_MUL_RD:  acc_r_reg <= MIX_W'(prod);
                    qapm_pkg::S_MUL_YAW: acc_r_reg <= acc_r_reg + MIX_W'(prod);
                    qapm_pkg::S_YAW_PT: begin
                        yt_reg <= MIX_W'(prod) - (MIX_W'(yc) <<< 16);
                        pt_reg <= (acc_p_reg <<< 8) + (MIX_W'(pi_reg) <<< 16);
                        u_reg  <= (MIX_W'(sr) + MIX_W'(hr) - MIX_W'(sp) - MIX_W'(hp)) <<< 15;
                        v_reg  <= (MIX_W'(sr) + MIX_W'(hr) + MIX_W'(sp) + MIX_W'(hp)) <<< 15;
                    end
                    qapm_pkg::S_RT_TY: begin
                        rt_reg  <= (acc_r_reg <<< 8) + (MIX_W'(ri_reg) <<< 16);
                        tys_reg <= (MIX_W'(th) <<< 16) + yt_reg;
                        tyd_reg <= (MIX_W'(th) <<< 16) - yt_reg;
                    end
                    qapm_pkg::S_XY: begin
                        xs_reg <= pt_reg - rt_reg;
                        ys_reg <= pt_reg + rt_reg;
                    end
                    qapm_pkg::S_EF: begin
                        e_reg <= u_reg + xs_reg;
                        f_reg <= v_reg - ys_reg;
                    end
                    default: ;
                endcase
            end
        end
    end

    // integrators advance only while flying
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pi_reg <= '0;
            ri_reg <= '0;
        end else if (ctrl.run && fly_reg) begin
            if (ctrl.step == qapm_pkg::S_MUL_IR) begin
                pi_reg <= int_step(pi_reg, prod, cfg.integral_limit);
            end
            if (ctrl.step == qapm_pkg::S_MUL_PP) begin
                ri_reg <= int_step(ri_reg, prod, cfg.integral_limit);
            end
        end
    end

    assign counts = {cnt_reg[3], cnt_reg[2], cnt_reg[1], cnt_reg[0]};

    a_int_hold_paused: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.run && !fly_reg) |=> ($stable(pi_reg) && $stable(ri_reg)))
        else $error("integrator moved while paused");

endmodule

`default_nettype wire

// ===== design/quad_attitude_pid_mixer.sv =====
// Top level of the quad attitude PID mixer: streaming ports, config port, output register.
// Depends on qapm_pkg; instantiates qapm_cfg, qapm_ctrl and qapm_dpath.
//
// Usage:
//   One beat on the s_ channel is one control tick: angles, angle changes, yaw gyro, thrust,
//   roll/pitch/yaw commands in tdata and the fly flag in tuser. Each accepted beat yields one
//   m_ beat with four 12-bit PWM off counts, or none while outputs_enabled is 0 (the
//   integrators still advance then).
//   Timing: the tick runs through a step sequencer around one shared multiplier: 7 PID
//   products, then 4 products per motor for the pulse-to-count conversion, 43 steps in all.
//   The result beat becomes valid in the same cycle that s_tready returns.
//   s_tready is low while a tick is in work.
//   Stall: the result sits in an output register, so a new tick is accepted while m_tready is
//   low; a finished tick waits in the done state until that register frees up.
//   Reset (aresetn low, synchronous): config registers take their defaults, both integrators
//   clear to zero, the sequencer goes idle and m_tvalid drops.
//   Config writes (cfg_wr_en, cfg_index, cfg_wr_data) take effect at the next edge and are
//   meant for idle periods only.
`default_nettype none

module quad_attitude_pid_mixer #(
    parameter int PWM_FREQ_HZ = qapm_pkg::PWM_FREQ_HZ_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // s_tdata, lowest bit up: pitch_angle[16], roll_angle[16], pitch_change[16],
    // roll_change[16], yaw_gyro[18], thrust_command[20], stick_roll[18], stick_pitch[18],
    // hold_roll[18], hold_pitch[18], yaw_command[18]
    input  wire logic [qapm_pkg::S_DATA_W-1:0]     s_tdata,
    input  wire logic                              s_tuser,   // fly
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // m_tdata, lowest bit up: motor_front_count[12], motor_second_count[12],
    // motor_third_count[12], motor_fourth_count[12]
    output logic [qapm_pkg::M_DATA_W-1:0]          m_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    input  wire logic                              cfg_wr_en,
    input  wire logic [2:0]                        cfg_index,
    input  wire logic [15:0]                       cfg_wr_data
);

    qapm_pkg::cfg_t  cfg;
    qapm_pkg::ctrl_t ctrl;

    logic                          out_free;
    logic [qapm_pkg::M_DATA_W-1:0] counts;
    logic                          m_tvalid_reg, m_tvalid_next;
    logic [qapm_pkg::M_DATA_W-1:0] m_tdata_reg;

    qapm_cfg u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg)
    );

    qapm_ctrl u_ctrl (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .out_free        (out_free),
        .outputs_enabled (cfg.outputs_enabled),
        .ctrl            (ctrl)
    );

    qapm_dpath #(
        .PWM_FREQ_HZ (PWM_FREQ_HZ)
    ) u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .cfg     (cfg),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .counts  (counts)
    );

    // output register: free when empty or when the current beat leaves this cycle
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (ctrl.push) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // load the counts with the push; hold them while stalled
    always_ff @(posedge aclk) begin
        if (ctrl.push) begin
            m_tdata_reg <= counts;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.push |-> (!m_tvalid_reg || m_tready))
        else $error("result pushed over an undelivered beat");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken again while a tick is in work");

endmodule

`default_nettype wire
